// File: hdl/ppm_pkg.sv
package ppm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 10;
	localparam int MAX_POS  = 1 << POS_W;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_RANK,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic rotate;
	} rank_ctl_t;

endpackage

// File: hdl/per_position_median_over_records_top.sv
// per-position temporal median over a ring of stored records
// input channel (in_valid/in_ready): action 0 writes sample_value at position of the
//   current record slot; end_of_record on a write advances the slot afterwards.
//   action 1 queries the median of the WINDOW_LEN samples held at position.
// output channel (out_valid/out_ready): one beat per query, filtered_value and
//   position_echo; writes produce no beat.
// a write leaves in_ready high: writes stream one per cycle while no query runs.
// a query in range steps through WINDOW_LEN reads on the single sample memory port,
//   a drain step, up to WINDOW_LEN rank steps on the shared comparator bank and a
//   final step to the output register. a query at or beyond RECORD_LEN goes straight
//   to that final step and returns zero. in_ready is low while a query is in progress.
// reset zeroes all WINDOW_LEN * 2**ceil(log2(min(RECORD_LEN,1024))) entries of the
//   sample memory (5120 by default) in a sweep; in_ready stays low until it ends.
// the result waits in the output register while out_ready is low; writes are still
//   taken meanwhile, and a following query waits in its last step until the
//   register frees.
module per_position_median_over_records_top
	import ppm_pkg::*;
#(
	parameter int WINDOW_LEN = 5,
	parameter int RECORD_LEN = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [POS_W-1:0]    position,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic                end_of_record,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] filtered_value,
	output logic [POS_W-1:0]    position_echo
);

	localparam int EFF_LEN = (RECORD_LEN < MAX_POS) ? RECORD_LEN : MAX_POS;
	localparam int PW      = (EFF_LEN > 1) ? $clog2(EFF_LEN) : 1;
	localparam int SW      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int AW      = SW + PW;
	localparam int DEPTH   = WINDOW_LEN << PW;
	localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW_LEN - 1);

	state_t              state_q, state_d;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       rd_cnt_q;
	logic                rd_pend_q;
	logic [POS_W-1:0]    pos_q;
	logic [SAMPLE_W-1:0] res_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] fv_q;
	logic [POS_W-1:0]    pe_q;

	logic                clr_busy;
	logic                acc;
	logic                pos_ok;
	logic                wr;
	logic                query;
	logic [AW-1:0]       mem_addr;
	logic                mem_re;
	logic [SAMPLE_W-1:0] mem_rdata;
	rank_ctl_t           rank_ctl;
	logic [SAMPLE_W-1:0] head;
	logic                hit;
	logic                res_load;
	logic                out_load;

	assign in_ready = (state_q == ST_IDLE) && !clr_busy;
	assign acc      = in_valid && in_ready;
	assign pos_ok   = 32'(position) < RECORD_LEN;
	assign wr       = acc && (action == ACT_WRITE) && pos_ok;
	assign query    = acc && (action == ACT_QUERY);
	assign mem_re   = (state_q == ST_READ);
	assign mem_addr = (state_q == ST_READ) ? {rd_cnt_q, pos_q[PW-1:0]}
	                                       : {slot_q, position[PW-1:0]};

	assign rank_ctl.load   = rd_pend_q;
	assign rank_ctl.rotate = (state_q == ST_RANK) && !hit;

	ppm_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.addr  (mem_addr),
		.we    (wr),
		.wdata (sample_value),
		.re    (mem_re),
		.rdata (mem_rdata),
		.busy  (clr_busy)
	);

	ppm_rank #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_rank (
		.clk (clk),
		.ctl (rank_ctl),
		.din (mem_rdata),
		.head(head),
		.hit (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (query) begin
					state_d = pos_ok ? ST_READ : ST_FIN;
				end
			end
			ST_READ: begin
				if (rd_cnt_q == LAST_SLOT) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RANK;
			end
			ST_RANK: begin
				if (hit) begin
					res_load = 1'b1;
					state_d  = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			rd_cnt_q    <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == ST_READ);
			if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end else begin
				rd_cnt_q <= '0;
			end
			if (acc && (action == ACT_WRITE) && end_of_record) begin
				slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query) begin
			pos_q <= position;
			res_q <= '0;
		end else if (res_load) begin
			res_q <= head;
		end
		if (out_load) begin
			fv_q <= res_q;
			pe_q <= pos_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = fv_q;
	assign position_echo  = pe_q;

endmodule

// File: hdl/ppm_store.sv
module ppm_store
	import ppm_pkg::*;
#(
	parameter int DEPTH = 5120,
	parameter int AW    = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [AW-1:0]       addr,
	input  logic                we,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic                re,
	output logic [SAMPLE_W-1:0] rdata,
	output logic                busy
);

	logic [SAMPLE_W-1:0] mem_q [DEPTH];
	logic [SAMPLE_W-1:0] rdata_q;
	logic [AW-1:0]       clr_cnt_q;
	logic                busy_q;

	// zero sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_cnt_q] <= '0;
		end else if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// File: hdl/ppm_rank.sv
module ppm_rank
	import ppm_pkg::*;
#(
	parameter int WINDOW_LEN = 5
) (
	input  logic                clk,
	input  rank_ctl_t           ctl,
	input  logic [SAMPLE_W-1:0] din,
	output logic [SAMPLE_W-1:0] head,
	output logic                hit
);

	localparam int CW = $clog2(WINDOW_LEN + 1);
	localparam logic [CW-1:0] MID = CW'(WINDOW_LEN / 2);

	logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] vals_q;
	logic [WINDOW_LEN-1:0]               lt;
	logic [WINDOW_LEN-1:0]               le;
	logic [CW-1:0]                       lt_cnt;
	logic [CW-1:0]                       le_cnt;
	logic [SAMPLE_W-1:0]                 tail_in;

	assign tail_in = ctl.load ? din : vals_q[0];

	// shift ring: loads enter at the tail, rotation brings the next candidate to the head
	always_ff @(posedge clk) begin
		if (ctl.load || ctl.rotate) begin
			for (int i = 0; i < WINDOW_LEN - 1; i++) begin
				vals_q[i] <= vals_q[i+1];
			end
			vals_q[WINDOW_LEN-1] <= tail_in;
		end
	end

	// compare head against every lane
	always_comb begin
		for (int j = 0; j < WINDOW_LEN; j++) begin
			lt[j] = vals_q[j] < vals_q[0];
			le[j] = vals_q[j] <= vals_q[0];
		end
		lt_cnt = CW'($countones(lt));
		le_cnt = CW'($countones(le));
	end

	assign head = vals_q[0];
	assign hit  = (lt_cnt <= MID) && (le_cnt > MID);

endmodule

// File: hdl/ppm_checker.sv
module ppm_checker
	import ppm_pkg::*;
#(
	parameter int RECORD_LEN = 1024
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                action,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SAMPLE_W-1:0] filtered_value,
	input logic [POS_W-1:0]    position_echo
);

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(filtered_value)
			&& $stable(position_echo))
	else $error("result beat changed while stalled");

	// a query occupies the block
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_QUERY) |=> !in_ready)
	else $error("input taken during a query");

	// writes stream without stalling the input
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_WRITE) |=> in_ready)
	else $error("write stalled the input");

	// a new result only follows a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
	else $error("result without a query in progress");

	// position beyond the record reads as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (32'(position_echo) >= RECORD_LEN) |-> filtered_value == '0)
	else $error("nonzero median beyond record");

endmodule

bind per_position_median_over_records_top ppm_checker #(
	.RECORD_LEN(RECORD_LEN)
) u_ppm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.action        (action),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.filtered_value(filtered_value),
	.position_echo (position_echo)
);

// File: tb/median_watch.sv
module median_watch
	import ppm_pkg::*;
#(
	parameter int WINDOW_LEN = 5,
	parameter int RECORD_LEN = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                action,
	input  logic [POS_W-1:0]    position,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic                end_of_record,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [SAMPLE_W-1:0] filtered_value,
	input  logic [POS_W-1:0]    position_echo,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic [POS_W-1:0]    pos;
	} median_beat_t;

	logic [SAMPLE_W-1:0] rec_mem [WINDOW_LEN][RECORD_LEN];
	int unsigned         cur_slot;
	median_beat_t        median_q [$];

	task automatic flag_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 100) begin
			$display("%0t mismatch: %s", $realtime, msg);
		end
	endtask

	// middle of the sorted column, upper middle for an even window
	function automatic logic [SAMPLE_W-1:0] median_at(input logic [POS_W-1:0] pos);
		logic [SAMPLE_W-1:0] col [WINDOW_LEN];
		logic [SAMPLE_W-1:0] tmp;
		if (int'(pos) >= RECORD_LEN) begin
			return '0;
		end
		for (int s = 0; s < WINDOW_LEN; s++) begin
			col[s] = rec_mem[s][pos];
		end
		for (int a = 0; a < WINDOW_LEN - 1; a++) begin
			for (int b = 0; b < WINDOW_LEN - 1 - a; b++) begin
				if (col[b] > col[b+1]) begin
					tmp      = col[b];
					col[b]   = col[b+1];
					col[b+1] = tmp;
				end
			end
		end
		return col[WINDOW_LEN/2];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		median_beat_t exp_beat;
		if (!arst_n) begin
			for (int s = 0; s < WINDOW_LEN; s++) begin
				for (int p = 0; p < RECORD_LEN; p++) begin
					rec_mem[s][p] = '0;
				end
			end
			cur_slot   = 0;
			fail_count = 0;
			median_q.delete();
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (median_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat value %h pos %0d",
						filtered_value, position_echo));
				end else begin
					exp_beat = median_q.pop_front();
					if (filtered_value !== exp_beat.value) begin
						flag_mismatch($sformatf("pos %0d filtered_value %h, want %h",
							exp_beat.pos, filtered_value, exp_beat.value));
					end
					if (position_echo !== exp_beat.pos) begin
						flag_mismatch($sformatf("position_echo %0d, want %0d",
							position_echo, exp_beat.pos));
					end
				end
			end
			if (in_valid && in_ready) begin
				if (action == ACT_QUERY) begin
					exp_beat.value = median_at(position);
					exp_beat.pos   = position;
					median_q.push_back(exp_beat);
				end else begin
					if (int'(position) < RECORD_LEN) begin
						rec_mem[cur_slot][position] = sample_value;
					end
					if (end_of_record) begin
						cur_slot = (cur_slot + 1) % WINDOW_LEN;
					end
				end
			end
			pending <= median_q.size();
		end
	end

endmodule

// File: tb/per_position_median_over_records_top_tb.sv
module per_position_median_over_records_top_tb;
	import ppm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          WINDOW_LEN     = 5;
	localparam int          RECORD_LEN     = 1024;
	localparam int          RAND_PER_PHASE = 228;
	localparam int          HOLD_CYCLES    = 400;
	localparam int unsigned RUN_LIMIT      = 400000;

	logic                clk;
	logic                arst_n         = 1'b0;
	logic                in_valid       = 1'b0;
	logic                in_ready;
	logic                action         = ACT_WRITE;
	logic [POS_W-1:0]    position       = '0;
	logic [SAMPLE_W-1:0] sample_value   = '0;
	logic                end_of_record  = 1'b0;
	logic                out_valid;
	logic                out_ready      = 1'b0;
	logic [SAMPLE_W-1:0] filtered_value;
	logic [POS_W-1:0]    position_echo;

	int          fail_count;
	int          pending;
	int          sender_idle_pct = 0;
	int          recv_stall_pct  = 0;
	int          hold_req        = 0;
	int unsigned cycle_count     = 0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	per_position_median_over_records_top #(
		.WINDOW_LEN(WINDOW_LEN),
		.RECORD_LEN(RECORD_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.position(position),
		.sample_value(sample_value),
		.end_of_record(end_of_record),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered_value(filtered_value),
		.position_echo(position_echo)
	);

	median_watch #(
		.WINDOW_LEN(WINDOW_LEN),
		.RECORD_LEN(RECORD_LEN)
	) watch (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.position(position),
		.sample_value(sample_value),
		.end_of_record(end_of_record),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filtered_value(filtered_value),
		.position_echo(position_echo),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// result side: random stalls plus a long hold when requested
	initial begin
		int holds_done;
		int held;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req != holds_done) begin
				holds_done = hold_req;
				out_ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++) begin
					@(posedge clk);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic offer_beat(input logic act, input logic [POS_W-1:0] pos,
			input logic [SAMPLE_W-1:0] val, input logic eor);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		position      <= pos;
		sample_value  <= val;
		end_of_record <= eor;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic put_sample(input logic [POS_W-1:0] pos, input logic [SAMPLE_W-1:0] val,
			input logic eor);
		offer_beat(ACT_WRITE, pos, val, eor);
	endtask

	task automatic ask_median(input logic [POS_W-1:0] pos, input logic eor);
		offer_beat(ACT_QUERY, pos, SAMPLE_W'($urandom_range(16'hFFFF)), eor);
	endtask

	task automatic drain_results();
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return SAMPLE_W'($urandom_range(3));
			default: return SAMPLE_W'($urandom_range(16'hFFFF));
		endcase
	endfunction

	initial begin
		logic [POS_W-1:0] hot_pos [8];
		logic [POS_W-1:0] pos;
		int               ph;
		int               n;
		int               k;
		int               roll;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// empty window reads zero, end mark on a query is ignored
		ask_median('0, 1'b0);
		ask_median('1, 1'b1);
		put_sample('1, 16'hFFFF, 1'b0);
		ask_median('1, 1'b0);
		put_sample('0, 16'hFFFF, 1'b1);
		put_sample('1, 16'h8000, 1'b1);
		put_sample('1, 16'h0001, 1'b1);
		ask_median('1, 1'b0);
		put_sample('1, 16'hFFFF, 1'b1);
		// slot wraps back to the first record
		put_sample('1, 16'h7FFF, 1'b1);
		ask_median('1, 1'b0);
		ask_median('0, 1'b0);
		put_sample('1, 16'h0000, 1'b0);
		ask_median('1, 1'b0);
		put_sample(10'h200, 16'h5555, 1'b0);
		put_sample(10'h200, 16'hAAAA, 1'b1);
		ask_median(10'h200, 1'b1);
		put_sample(10'h155, 16'h00FF, 1'b0);
		put_sample(10'h2AA, 16'hFF00, 1'b1);
		ask_median(10'h155, 1'b0);
		ask_median(10'h2AA, 1'b0);
		put_sample(10'h155, 16'h00FF, 1'b1);
		ask_median(10'h155, 1'b0);
		in_valid <= 1'b0;
		drain_results();

		// long output hold so the query path backs up into the input
		hold_req = hold_req + 1;
		for (n = 0; n < 16; n++) begin
			pos = POS_W'($urandom_range(3));
			if (n % 2 == 1) begin
				ask_median(pos, 1'b0);
			end else begin
				put_sample(pos, pick_sample(), n % 4 == 0);
			end
		end
		in_valid <= 1'b0;
		drain_results();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
				end
				1: begin
					sender_idle_pct = 71;
					recv_stall_pct  = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 71;
				end
				default: begin
					sender_idle_pct = 15;
					recv_stall_pct  = 15;
				end
			endcase
			for (k = 0; k < 8; k++) begin
				hot_pos[k] = (k < 4) ? POS_W'($urandom_range(7))
					: POS_W'($urandom_range(MAX_POS - 1));
			end
			for (n = 0; n < RAND_PER_PHASE; n++) begin
				roll = $urandom_range(99);
				if (roll < 45) begin
					put_sample(hot_pos[$urandom_range(7)], pick_sample(),
						$urandom_range(5) == 0);
				end else if (roll < 85) begin
					ask_median(hot_pos[$urandom_range(7)], 1'($urandom_range(1)));
				end else if (roll < 92) begin
					put_sample(POS_W'($urandom_range(MAX_POS - 1)), pick_sample(),
						$urandom_range(5) == 0);
				end else begin
					ask_median(POS_W'($urandom_range(MAX_POS - 1)),
						1'($urandom_range(1)));
				end
			end
			in_valid <= 1'b0;
			drain_results();
		end

		repeat (2 * WINDOW_LEN + 8) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: per_position_median_over_records_top.f
hdl/ppm_pkg.sv
hdl/ppm_store.sv
hdl/ppm_rank.sv
hdl/per_position_median_over_records_top.sv
hdl/ppm_checker.sv
tb/median_watch.sv
tb/per_position_median_over_records_top_tb.sv
